// ===== design/rvdec_pkg.sv =====
`timescale 1ns / 1ps
package rvdec_pkg;

  localparam int unsigned XLEN    = 32;
  localparam int unsigned REG_W   = 5;
  localparam int unsigned OP_W    = 5;
  // Shift amount width follows from the register width of the target.
  localparam int unsigned SHAMT_W = $clog2(XLEN);

  // Major opcodes, instruction bits 6:0.
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_JAL      = 7'h6F;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_OP_FP    = 7'h53;
  localparam logic [6:0] OPC_LOAD_FP  = 7'h07;
  localparam logic [6:0] OPC_STORE_FP = 7'h27;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;

  localparam logic [6:0] F7_FADD   = 7'h00;
  localparam logic [6:0] F7_FSUB   = 7'h04;
  localparam logic [6:0] F7_FMUL   = 7'h08;
  localparam logic [6:0] F7_FDIV   = 7'h0C;
  localparam logic [6:0] F7_FMINMAX = 7'h14;
  localparam logic [6:0] F7_FSQRT  = 7'h2C;

  typedef enum logic [3:0] {
    UNIT_ALUREG = 4'd0,
    UNIT_ALUIMM = 4'd1,
    UNIT_LOAD   = 4'd2,
    UNIT_STORE  = 4'd3,
    UNIT_BRANCH = 4'd4,
    UNIT_AUIPC  = 4'd5,
    UNIT_LUI    = 4'd6,
    UNIT_JAL    = 4'd7,
    UNIT_JALR   = 4'd8,
    UNIT_FPU    = 4'd9,
    UNIT_FLOAD  = 4'd10,
    UNIT_FSTORE = 4'd11
  } unit_t;

  // Register ALU operations.
  localparam logic [OP_W-1:0] ALU_ADD    = 5'd0;
  localparam logic [OP_W-1:0] ALU_SUB    = 5'd1;
  localparam logic [OP_W-1:0] ALU_SLL    = 5'd2;
  localparam logic [OP_W-1:0] ALU_SLT    = 5'd3;
  localparam logic [OP_W-1:0] ALU_SLTU   = 5'd4;
  localparam logic [OP_W-1:0] ALU_XOR    = 5'd5;
  localparam logic [OP_W-1:0] ALU_SRL    = 5'd6;
  localparam logic [OP_W-1:0] ALU_SRA    = 5'd7;
  localparam logic [OP_W-1:0] ALU_OR     = 5'd8;
  localparam logic [OP_W-1:0] ALU_AND    = 5'd9;
  localparam logic [OP_W-1:0] ALU_MUL    = 5'd10;
  localparam logic [OP_W-1:0] ALU_MULH   = 5'd11;
  localparam logic [OP_W-1:0] ALU_MULHSU = 5'd12;
  localparam logic [OP_W-1:0] ALU_MULHU  = 5'd13;
  localparam logic [OP_W-1:0] ALU_DIV    = 5'd14;
  localparam logic [OP_W-1:0] ALU_DIVU   = 5'd15;
  localparam logic [OP_W-1:0] ALU_REM    = 5'd16;
  localparam logic [OP_W-1:0] ALU_REMU   = 5'd17;

  // Immediate ALU operations.
  localparam logic [OP_W-1:0] IMM_ADDI  = 5'd0;
  localparam logic [OP_W-1:0] IMM_SLTI  = 5'd1;
  localparam logic [OP_W-1:0] IMM_SLTIU = 5'd2;
  localparam logic [OP_W-1:0] IMM_XORI  = 5'd3;
  localparam logic [OP_W-1:0] IMM_ORI   = 5'd4;
  localparam logic [OP_W-1:0] IMM_ANDI  = 5'd5;
  localparam logic [OP_W-1:0] IMM_SLLI  = 5'd6;
  localparam logic [OP_W-1:0] IMM_SRLI  = 5'd7;
  localparam logic [OP_W-1:0] IMM_SRAI  = 5'd8;

  localparam logic [OP_W-1:0] LD_LB  = 5'd0;
  localparam logic [OP_W-1:0] LD_LH  = 5'd1;
  localparam logic [OP_W-1:0] LD_LW  = 5'd2;
  localparam logic [OP_W-1:0] LD_LBU = 5'd3;
  localparam logic [OP_W-1:0] LD_LHU = 5'd4;

  localparam logic [OP_W-1:0] ST_SB = 5'd0;
  localparam logic [OP_W-1:0] ST_SH = 5'd1;
  localparam logic [OP_W-1:0] ST_SW = 5'd2;

  localparam logic [OP_W-1:0] BR_BEQ  = 5'd0;
  localparam logic [OP_W-1:0] BR_BNE  = 5'd1;
  localparam logic [OP_W-1:0] BR_BLT  = 5'd2;
  localparam logic [OP_W-1:0] BR_BGE  = 5'd3;
  localparam logic [OP_W-1:0] BR_BLTU = 5'd4;
  localparam logic [OP_W-1:0] BR_BGEU = 5'd5;

  localparam logic [OP_W-1:0] FP_ADD  = 5'd0;
  localparam logic [OP_W-1:0] FP_SUB  = 5'd1;
  localparam logic [OP_W-1:0] FP_MUL  = 5'd2;
  localparam logic [OP_W-1:0] FP_SQRT = 5'd3;
  localparam logic [OP_W-1:0] FP_DIV  = 5'd4;
  localparam logic [OP_W-1:0] FP_MIN  = 5'd5;
  localparam logic [OP_W-1:0] FP_MAX  = 5'd6;

  // Units with a single operation.
  localparam logic [OP_W-1:0] OP_ONLY = 5'd0;

  typedef struct packed {
    logic                   illegal;
    unit_t                  unit;
    logic [OP_W-1:0]        operation;
    logic [REG_W-1:0]       dest_reg;
    logic [REG_W-1:0]       src1_reg;
    logic [REG_W-1:0]       src2_reg;
    logic signed [XLEN-1:0] immediate;
    logic                   dest_is_float;
    logic                   src1_is_float;
    logic                   src2_is_float;
  } dec_result_t;

endpackage

// ===== design/rvdec_in_if.sv =====
`timescale 1ns / 1ps
interface rvdec_in_if;
  import rvdec_pkg::*;

  logic            valid;
  logic            ready;
  logic [XLEN-1:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

// ===== design/rvdec_out_if.sv =====
`timescale 1ns / 1ps
interface rvdec_out_if;
  import rvdec_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   illegal;
  logic [3:0]             unit;
  logic [OP_W-1:0]        operation;
  logic [REG_W-1:0]       dest_reg;
  logic [REG_W-1:0]       src1_reg;
  logic [REG_W-1:0]       src2_reg;
  logic signed [XLEN-1:0] immediate;
  logic                   dest_is_float;
  logic                   src1_is_float;
  logic                   src2_is_float;

  modport source (
    output valid, output illegal, output unit, output operation,
    output dest_reg, output src1_reg, output src2_reg, output immediate,
    output dest_is_float, output src1_is_float, output src2_is_float,
    input ready
  );
  modport sink (
    input valid, input illegal, input unit, input operation,
    input dest_reg, input src1_reg, input src2_reg, input immediate,
    input dest_is_float, input src1_is_float, input src2_is_float,
    output ready
  );
endinterface

// ===== design/rvdec_decode.sv =====
`timescale 1ns / 1ps
module rvdec_decode (
  input  logic [rvdec_pkg::XLEN-1:0] instruction,
  output rvdec_pkg::dec_result_t     result
);
  import rvdec_pkg::*;

  logic [6:0]       opc;
  logic [REG_W-1:0] rd;
  logic [2:0]       f3;
  logic [REG_W-1:0] rs1;
  logic [REG_W-1:0] rs2;
  logic [6:0]       f7;
  logic [XLEN-1:0]  imm_i;
  logic [XLEN-1:0]  imm_s;
  logic [XLEN-1:0]  imm_b;
  logic [XLEN-1:0]  imm_u;
  logic [XLEN-1:0]  imm_j;
  logic [XLEN-1:0]  imm_shamt;

  logic             ok;
  unit_t            unit;
  logic [OP_W-1:0]  op;
  logic [REG_W-1:0] d;
  logic [REG_W-1:0] s1;
  logic [REG_W-1:0] s2;
  logic [XLEN-1:0]  imm;
  logic             df;
  logic             s1f;
  logic             s2f;

  assign opc = instruction[6:0];
  assign rd  = instruction[11:7];
  assign f3  = instruction[14:12];
  assign rs1 = instruction[19:15];
  assign rs2 = instruction[24:20];
  assign f7  = instruction[31:25];

  assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
  assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
  assign imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
                  instruction[30:25], instruction[11:8], 1'b0};
  assign imm_u = {instruction[31:12], 12'h000};
  assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                  instruction[20], instruction[30:21], 1'b0};
  assign imm_shamt = {{(XLEN-SHAMT_W){1'b0}}, instruction[20 +: SHAMT_W]};

  always_comb begin
    ok   = 1'b0;
    unit = UNIT_ALUREG;
    op   = OP_ONLY;
    d    = '0;
    s1   = '0;
    s2   = '0;
    imm  = '0;
    df   = 1'b0;
    s1f  = 1'b0;
    s2f  = 1'b0;
    unique case (opc)
      OPC_OP: begin
        unit = UNIT_ALUREG;
        d = rd; s1 = rs1; s2 = rs2;
        if (f7 == F7_BASE) begin
          ok = 1'b1;
          unique case (f3)
            3'd0: op = ALU_ADD;
            3'd1: op = ALU_SLL;
            3'd2: op = ALU_SLT;
            3'd3: op = ALU_SLTU;
            3'd4: op = ALU_XOR;
            3'd5: op = ALU_SRL;
            3'd6: op = ALU_OR;
            default: op = ALU_AND;
          endcase
        end else if (f7 == F7_MULDIV) begin
          ok = 1'b1;
          unique case (f3)
            3'd0: op = ALU_MUL;
            3'd1: op = ALU_MULH;
            3'd2: op = ALU_MULHSU;
            3'd3: op = ALU_MULHU;
            3'd4: op = ALU_DIV;
            3'd5: op = ALU_DIVU;
            3'd6: op = ALU_REM;
            default: op = ALU_REMU;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == 3'd0) begin
            ok = 1'b1; op = ALU_SUB;
          end else if (f3 == 3'd5) begin
            ok = 1'b1; op = ALU_SRA;
          end
        end
      end
      OPC_OP_IMM: begin
        unit = UNIT_ALUIMM;
        d = rd; s1 = rs1; imm = imm_i;
        unique case (f3)
          3'd0: begin ok = 1'b1; op = IMM_ADDI; end
          3'd2: begin ok = 1'b1; op = IMM_SLTI; end
          3'd3: begin ok = 1'b1; op = IMM_SLTIU; end
          3'd4: begin ok = 1'b1; op = IMM_XORI; end
          3'd6: begin ok = 1'b1; op = IMM_ORI; end
          3'd7: begin ok = 1'b1; op = IMM_ANDI; end
          3'd1: begin
            imm = imm_shamt;
            if (f7 == F7_BASE) begin
              ok = 1'b1; op = IMM_SLLI;
            end
          end
          default: begin
            imm = imm_shamt;
            if (f7 == F7_BASE) begin
              ok = 1'b1; op = IMM_SRLI;
            end else if (f7 == F7_ALT) begin
              ok = 1'b1; op = IMM_SRAI;
            end
          end
        endcase
      end
      OPC_LOAD: begin
        unit = UNIT_LOAD;
        d = rd; s1 = rs1; imm = imm_i;
        unique case (f3)
          3'd0: begin ok = 1'b1; op = LD_LB; end
          3'd1: begin ok = 1'b1; op = LD_LH; end
          3'd2: begin ok = 1'b1; op = LD_LW; end
          3'd4: begin ok = 1'b1; op = LD_LBU; end
          3'd5: begin ok = 1'b1; op = LD_LHU; end
          default: ok = 1'b0;
        endcase
      end
      OPC_STORE: begin
        unit = UNIT_STORE;
        s1 = rs1; s2 = rs2; imm = imm_s;
        unique case (f3)
          3'd0: begin ok = 1'b1; op = ST_SB; end
          3'd1: begin ok = 1'b1; op = ST_SH; end
          3'd2: begin ok = 1'b1; op = ST_SW; end
          default: ok = 1'b0;
        endcase
      end
      OPC_BRANCH: begin
        unit = UNIT_BRANCH;
        s1 = rs1; s2 = rs2; imm = imm_b;
        unique case (f3)
          3'd0: begin ok = 1'b1; op = BR_BEQ; end
          3'd1: begin ok = 1'b1; op = BR_BNE; end
          3'd4: begin ok = 1'b1; op = BR_BLT; end
          3'd5: begin ok = 1'b1; op = BR_BGE; end
          3'd6: begin ok = 1'b1; op = BR_BLTU; end
          3'd7: begin ok = 1'b1; op = BR_BGEU; end
          default: ok = 1'b0;
        endcase
      end
      OPC_AUIPC: begin
        unit = UNIT_AUIPC; ok = 1'b1; d = rd; imm = imm_u;
      end
      OPC_LUI: begin
        unit = UNIT_LUI; ok = 1'b1; d = rd; imm = imm_u;
      end
      OPC_JAL: begin
        unit = UNIT_JAL; ok = 1'b1; d = rd; imm = imm_j;
      end
      OPC_JALR: begin
        unit = UNIT_JALR;
        d = rd; s1 = rs1; imm = imm_i;
        ok = (f3 == 3'd0);
      end
      OPC_OP_FP: begin
        unit = UNIT_FPU;
        d = rd; s1 = rs1; s2 = rs2;
        df = 1'b1; s1f = 1'b1; s2f = 1'b1;
        // The rounding-mode field is neither checked nor reported.
        unique case (f7)
          F7_FADD: begin ok = 1'b1; op = FP_ADD; end
          F7_FSUB: begin ok = 1'b1; op = FP_SUB; end
          F7_FMUL: begin ok = 1'b1; op = FP_MUL; end
          F7_FDIV: begin ok = 1'b1; op = FP_DIV; end
          F7_FSQRT: begin
            ok = (rs2 == '0); op = FP_SQRT;
          end
          F7_FMINMAX: begin
            if (f3 == 3'd0) begin
              ok = 1'b1; op = FP_MIN;
            end else if (f3 == 3'd1) begin
              ok = 1'b1; op = FP_MAX;
            end
          end
          default: ok = 1'b0;
        endcase
      end
      OPC_LOAD_FP: begin
        unit = UNIT_FLOAD;
        d = rd; s1 = rs1; imm = imm_i; df = 1'b1;
        ok = (f3 == 3'd2);
      end
      OPC_STORE_FP: begin
        unit = UNIT_FSTORE;
        s1 = rs1; s2 = rs2; imm = imm_s; s2f = 1'b1;
        ok = (f3 == 3'd2);
      end
      default: ok = 1'b0;
    endcase
  end

  // An illegal word reports nothing but the flag.
  always_comb begin
    result = '0;
    if (!ok) begin
      result.illegal = 1'b1;
    end else begin
      result.unit          = unit;
      result.operation     = op;
      result.dest_reg      = d;
      result.src1_reg      = s1;
      result.src2_reg      = s2;
      result.immediate     = imm;
      result.dest_is_float = df;
      result.src1_is_float = s1f;
      result.src2_is_float = s2f;
    end
  end

endmodule

// ===== design/rvdec_out_reg.sv =====
`timescale 1ns / 1ps
module rvdec_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rvdec_pkg::dec_result_t in_result,
  rvdec_out_if.source            decoded
);
  import rvdec_pkg::*;

  logic        valid;
  dec_result_t result;

  // The register takes a new word whenever it is empty or being drained.
  assign in_ready = !valid || decoded.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result <= in_result;
    end
  end

  assign decoded.valid         = valid;
  assign decoded.illegal       = result.illegal;
  assign decoded.unit          = result.unit;
  assign decoded.operation     = result.operation;
  assign decoded.dest_reg      = result.dest_reg;
  assign decoded.src1_reg      = result.src1_reg;
  assign decoded.src2_reg      = result.src2_reg;
  assign decoded.immediate     = result.immediate;
  assign decoded.dest_is_float = result.dest_is_float;
  assign decoded.src1_is_float = result.src1_is_float;
  assign decoded.src2_is_float = result.src2_is_float;

endmodule

// ===== design/rv32imf_instruction_decoder.sv =====
`timescale 1ns / 1ps
// RV32IMF instruction decoder.
// The fetch channel carries one raw 32-bit instruction word per handshake.
// The decoded channel returns one word per instruction, in order: unit class,
// operation, register numbers, float-register flags, immediate (sign-extended,
// shift amounts zero-extended) and an illegal flag. An illegal instruction
// returns only the flag set, with every other field zero.
// The instruction is captured in an input register, decoded by a short
// combinational network and captured again in the result register, which
// drives the decoded channel. Throughput is one instruction per cycle while
// decoded ready stays high; each register stage loads whenever it is empty or
// the stage after it is moving.
// When the receiver holds ready low, the result register keeps its word and
// the input register can still take one more instruction; fetch ready drops
// only when both stages are full.
// Synchronous reset empties both stages; no words are presented after reset
// until new instructions arrive.
module rv32imf_instruction_decoder (
  input  logic        clk,
  input  logic        rst,
  rvdec_in_if.sink    fetch,
  rvdec_out_if.source decoded
);
  import rvdec_pkg::*;

  logic            in_valid;
  logic [XLEN-1:0] in_instr;
  logic            out_ready;
  dec_result_t     dec_result;

  assign fetch.ready = !in_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (fetch.ready) begin
      in_valid <= fetch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch.ready && fetch.valid) begin
      in_instr <= fetch.instruction;
    end
  end

  rvdec_decode u_decode (
    .instruction (in_instr),
    .result      (dec_result)
  );

  rvdec_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (out_ready),
    .in_result (dec_result),
    .decoded   (decoded)
  );

endmodule
